>>> sv/cpbc_pkg.sv
// Shared types and constants for the camera parallel bus capture block.
`default_nettype none

package cpbc_pkg;

  // Width of the per-frame byte counter.
  localparam int unsigned FRAME_COUNT_WIDTH = 32;
  localparam int unsigned CMP_W = ((FRAME_COUNT_WIDTH > 32) ? FRAME_COUNT_WIDTH : 32) + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_TO_DECODE = 2'd0,
    REG_DATA_BITS        = 2'd1,
    REG_REPORT_LINES     = 2'd2,
    REG_REPORT_FRAMES    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_LINE_END  = 2'd1,
    KIND_FRAME_END = 2'd2
  } kind_e;

  typedef struct packed {
    logic       vsync_level;
    logic       hsync_level;
    logic [7:0] pixel_bus;
  } in_item_t;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   pixel_value;
    logic [31:0]  count_value;
    logic [15:0]  lines_in_frame;
    logic         length_mismatch;
    logic         last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;      // commit the sample now on the input
    logic load_item;   // latch the pixel or line end result
    logic mul_en;      // form last line length times line count
    logic load_frame;  // latch the frame end result and close the frame
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;           // the sample gives a pixel or line end result
    logic frame_end;      // the sample closes the frame
    logic report_frames;  // frame end results are enabled
  } dp_status_t;

endpackage

`default_nettype wire

>>> sv/camera_parallel_bus_capture_top.sv
// Top level of the camera parallel bus capture block.
// Usage:
//   Input channel: one item per pixel clock sample (vsync, hsync, data byte),
//   handed over with in_valid_i high and in_stall_o low.
//   Output channel: pixel, line end and frame end items, taken with
//   out_valid_o high and out_stall_i low. The last item caused by a sample
//   carries last set.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 frames to decode, 1 data bits, 2 report lines, 3 report frames).
//   Result path: a pixel or line end item appears in the cycle after its sample.
//   A frame closing sample then passes through the multiply step and the
//   compare step, which waits for the output register, before its frame end item is registered.
//   Throughput: one sample a cycle while in_stall_o is low; after a frame
//   closing sample no sample is taken until the multiply and compare steps of the frame end check are done.
//   Reset: clears the counters, empties the output register and loads the
//   register defaults; the first frame opens on a vsync fall after a high.
//   Stall: a result waits in the output register; while it is held,
//   in_stall_o rises and no further sample is taken.
`default_nettype none

module camera_parallel_bus_capture_top
  import cpbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cpbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cpbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sv/cpbc_ctrl.sv
// Controller: sequences sample acceptance, frame end check and the output register.
`default_nettype none

module cpbc_ctrl
  import cpbc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_CMP  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   out_taken;
  logic   load;

  assign out_taken = out_valid_q && !out_stall_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    load       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          cmd_o.accept    = 1'b1;
          cmd_o.load_item = status_i.emit;
          load            = status_i.emit;
          if (status_i.frame_end) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        // hold until the output register can take the frame end item
        if (out_free) begin
          cmd_o.load_frame = 1'b1;
          load             = status_i.report_frames;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/cpbc_dp.sv
// Datapath: configuration, sync tracking, counters, frame end check and output payload.
`default_nettype none

module cpbc_dp
  import cpbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_item_t              in_data_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 status_o,
  output out_item_t                  out_data_o
);

  // configuration
  logic [3:0]  data_bits_q;
  logic        report_lines_q;
  logic        report_frames_q;

  // capture state
  logic                         prev_vsync_q;
  logic                         frame_open_q;
  logic                         line_open_q;
  logic [15:0]                  bytes_line_q;
  logic [15:0]                  bytes_last_q;
  logic [15:0]                  lines_frame_q;
  logic [FRAME_COUNT_WIDTH-1:0] bytes_frame_q;
  logic [15:0]                  frames_left_q;

  logic [31:0] prod_q;
  out_item_t   out_q;

  logic        vs, hs;
  logic        opening, active, closing_line;
  logic [7:0]  mask;
  logic [15:0] lines_eff;
  out_item_t   item_res, frame_res;
  logic [CMP_W-1:0] tot_ext, prod_ext, diff, cnt_wide;
  logic        mis;

  assign vs = in_data_i.vsync_level;
  assign hs = in_data_i.hsync_level;

  assign opening      = !frame_open_q && prev_vsync_q && !vs && (frames_left_q != 16'd0);
  assign active       = frame_open_q || opening;
  assign closing_line = active && !hs && line_open_q;

  assign status_o.emit          = active && (hs || (line_open_q && report_lines_q));
  assign status_o.frame_end     = active && !hs && vs;
  assign status_o.report_frames = report_frames_q;

  assign mask = (data_bits_q >= 4'd8) ? 8'hFF : 8'((16'd1 << data_bits_q) - 16'd1);

  always_comb begin
    item_res                 = '0;
    item_res.kind            = hs ? KIND_PIXEL : KIND_LINE_END;
    item_res.pixel_value     = hs ? (in_data_i.pixel_bus & mask) : 8'd0;
    item_res.count_value     = hs ? 32'd0 : {16'd0, bytes_line_q};
    item_res.last            = !(status_o.frame_end && report_frames_q);
  end

  // total / lines == last  <=>  last*lines <= total < last*lines + lines
  assign lines_eff = (lines_frame_q == 16'd0) ? 16'd1 : lines_frame_q;
  assign tot_ext   = CMP_W'(bytes_frame_q);
  assign prod_ext  = CMP_W'(prod_q);
  assign diff      = tot_ext - prod_ext;
  assign mis       = (tot_ext < prod_ext) || (diff >= CMP_W'(lines_eff));
  assign cnt_wide  = mis ? tot_ext : CMP_W'(bytes_last_q);

  always_comb begin
    frame_res                 = '0;
    frame_res.kind            = KIND_FRAME_END;
    frame_res.count_value     = (cnt_wide > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : cnt_wide[31:0];
    frame_res.lines_in_frame  = lines_eff;
    frame_res.length_mismatch = mis;
    frame_res.last            = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q        <= 4'd8;
      report_lines_q     <= 1'b1;
      report_frames_q    <= 1'b1;
      prev_vsync_q       <= 1'b0;
      frame_open_q       <= 1'b0;
      line_open_q        <= 1'b0;
      bytes_line_q       <= '0;
      bytes_last_q       <= '0;
      lines_frame_q      <= '0;
      bytes_frame_q      <= '0;
      frames_left_q      <= 16'd1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_FRAMES_TO_DECODE: begin
            frames_left_q <= cfg_data_i[15:0];
          end
          REG_DATA_BITS:     data_bits_q     <= cfg_data_i[3:0];
          REG_REPORT_LINES:  report_lines_q  <= cfg_data_i[0];
          REG_REPORT_FRAMES: report_frames_q <= cfg_data_i[0];
          default: ;
        endcase
      end else if (cmd_i.accept && opening) begin
        frames_left_q <= frames_left_q - 16'd1;
      end

      if (cmd_i.accept) begin
        prev_vsync_q <= vs;
        if (opening) begin
          frame_open_q <= 1'b1;
        end
        if (active && hs) begin
          line_open_q <= 1'b1;
          if (bytes_line_q != 16'hFFFF) begin
            bytes_line_q <= bytes_line_q + 16'd1;
          end
          if (bytes_frame_q != '1) begin
            bytes_frame_q <= bytes_frame_q + FRAME_COUNT_WIDTH'(1);
          end
        end
        if (closing_line) begin
          line_open_q  <= 1'b0;
          bytes_last_q <= bytes_line_q;
          bytes_line_q <= '0;
          if (lines_frame_q != 16'hFFFF) begin
            lines_frame_q <= lines_frame_q + 16'd1;
          end
        end
      end

      // close the frame once its result is formed
      if (cmd_i.load_frame) begin
        frame_open_q  <= 1'b0;
        lines_frame_q <= '0;
        bytes_frame_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= {16'd0, bytes_last_q} * {16'd0, lines_eff};
    end
    if (cmd_i.load_item) begin
      out_q <= item_res;
    end else if (cmd_i.load_frame) begin
      out_q <= frame_res;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> sv/cpbc_checker.sv
// Port checker for the camera parallel bus capture block, with its bind.
`default_nettype none

module cpbc_checker
  import cpbc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // a held item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_pixel_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_PIXEL |->
      out_data_o.count_value == 32'd0 && out_data_o.lines_in_frame == 16'd0 &&
      !out_data_o.length_mismatch)
    else $error("pixel item carries count fields");

  a_line_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_LINE_END |->
      out_data_o.pixel_value == 8'd0 && out_data_o.lines_in_frame == 16'd0 &&
      !out_data_o.length_mismatch && out_data_o.count_value[31:16] == 16'd0)
    else $error("line end item malformed");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_FRAME_END |->
      out_data_o.last && out_data_o.lines_in_frame != 16'd0 &&
      out_data_o.pixel_value == 8'd0)
    else $error("frame end item malformed");

endmodule

bind camera_parallel_bus_capture_top cpbc_checker u_cpbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> test/camera_parallel_bus_capture_top_tb.sv
// Self-checking testbench for the camera parallel bus capture block.
`timescale 1ns / 100ps

module camera_parallel_bus_capture_top_tb;
  import cpbc_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_FRAMES_TO_DECODE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;

  camera_parallel_bus_capture_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Capture state as the block should hold it
  logic [3:0]                   kept_bits       = 4'd8;
  logic                         line_reports_on = 1'b1;
  logic                         frame_reports_on = 1'b1;
  logic                         last_vsync      = 1'b0;
  logic                         frame_active    = 1'b0;
  logic                         line_active     = 1'b0;
  logic [15:0]                  line_bytes      = '0;
  logic [15:0]                  prev_line_bytes = '0;
  logic [15:0]                  frame_lines     = '0;
  logic [FRAME_COUNT_WIDTH-1:0] frame_bytes     = '0;
  logic [15:0]                  frames_left     = 16'd1;

  out_item_t   pending[$];
  int unsigned mismatches    = 0;
  int unsigned samples_used  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_hold    = 0;
  logic        hold_request  = 1'b0;
  logic        hold_served   = 1'b0;

  // Work out the results one accepted sample causes and queue them
  task automatic predict_sample(input in_item_t s);
    out_item_t   caused[$];
    out_item_t   r;
    logic        was_high;
    logic [3:0]  bits;
    logic [8:0]  mask;
    logic [63:0] total;
    logic [63:0] cnt;
    logic [15:0] lines;
    logic        mis;
    was_high   = last_vsync;
    last_vsync = s.vsync_level;
    if (!frame_active) begin
      if (was_high && !s.vsync_level && frames_left != 0) begin
        frame_active = 1'b1;
        frames_left  = frames_left - 16'd1;
      end else begin
        return;
      end
    end
    samples_used++;
    if (s.hsync_level) begin
      bits = (kept_bits > 4'd8) ? 4'd8 : kept_bits;
      mask = (9'd1 << bits) - 9'd1;
      line_active = 1'b1;
      if (line_bytes != 16'hFFFF) line_bytes = line_bytes + 16'd1;
      if (frame_bytes != '1) frame_bytes = frame_bytes + FRAME_COUNT_WIDTH'(1);
      r = '0;
      r.kind = KIND_PIXEL;
      r.pixel_value = s.pixel_bus & mask[7:0];
      caused = {caused, r};
    end else begin
      if (line_active) begin
        line_active = 1'b0;
        if (line_reports_on) begin
          r = '0;
          r.kind = KIND_LINE_END;
          r.count_value = 32'(line_bytes);
          caused = {caused, r};
        end
        prev_line_bytes = line_bytes;
        line_bytes = '0;
        if (frame_lines != 16'hFFFF) frame_lines = frame_lines + 16'd1;
      end
      if (s.vsync_level) begin
        lines = (frame_lines == 0) ? 16'd1 : frame_lines;
        total = 64'(frame_bytes);
        mis   = (total / 64'(lines)) != 64'(prev_line_bytes);
        cnt   = mis ? total : 64'(prev_line_bytes);
        if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
        if (frame_reports_on) begin
          r = '0;
          r.kind = KIND_FRAME_END;
          r.count_value = cnt[31:0];
          r.lines_in_frame = lines;
          r.length_mismatch = mis;
          caused = {caused, r};
        end
        frame_active = 1'b0;
        frame_lines  = '0;
        frame_bytes  = '0;
      end
    end
    if (caused.size() > 0) caused[caused.size()-1].last = 1'b1;
    pending = {pending, caused};
  endtask

  task automatic send_sample(input logic vs, input logic hs, input logic [7:0] bus);
    in_item_t s;
    s.vsync_level = vs;
    s.hsync_level = hs;
    s.pixel_bus   = bus;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    predict_sample(s);
  endtask

  // Drop valid, wait for every expected item, then let a frame end finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRAMES_TO_DECODE: begin
        frames_left  = value;
      end
      REG_DATA_BITS:     kept_bits = value[3:0];
      REG_REPORT_LINES:  line_reports_on = value[0];
      REG_REPORT_FRAMES: frame_reports_on = value[0];
      default: ;
    endcase
  endtask

  // Start level, frame opening sample, vsync inside a line, line and frame
  // closing together, and input ignored once the frames run out
  task automatic test_sync_cases();
    send_sample(1'b0, 1'b0, 8'h00);
    send_sample(1'b0, 1'b1, 8'hAA);
    send_sample(1'b1, 1'b0, 8'h00);
    send_sample(1'b0, 1'b1, 8'hFF);
    send_sample(1'b0, 1'b1, 8'h00);
    send_sample(1'b1, 1'b1, 8'h5A);
    send_sample(1'b1, 1'b0, 8'h00);
    send_sample(1'b0, 1'b1, 8'h11);
    send_sample(1'b1, 1'b0, 8'h00);
    send_sample(1'b0, 1'b1, 8'h22);
    send_sample(1'b1, 1'b0, 8'h00);
    drain();
  endtask

  // Data bit extremes, suppressed reports, empty frame, mismatch, and a
  // quota rewrite while a frame is open
  task automatic test_register_settings();
    write_reg(REG_FRAMES_TO_DECODE, 16'hFFFF);
    write_reg(REG_DATA_BITS, 16'd0);
    send_sample(1'b0, 1'b1, 8'hFF);
    send_sample(1'b0, 1'b0, 8'h00);
    send_sample(1'b0, 1'b1, 8'h81);
    send_sample(1'b0, 1'b1, 8'h7E);
    send_sample(1'b0, 1'b0, 8'h00);
    send_sample(1'b1, 1'b0, 8'h00);
    drain();
    write_reg(REG_DATA_BITS, 16'd15);
    write_reg(REG_REPORT_LINES, 16'd0);
    send_sample(1'b0, 1'b0, 8'h00);
    send_sample(1'b1, 1'b0, 8'h00);
    send_sample(1'b0, 1'b1, 8'h80);
    send_sample(1'b1, 1'b1, 8'hC3);
    send_sample(1'b1, 1'b0, 8'h00);
    drain();
    write_reg(REG_REPORT_FRAMES, 16'd0);
    write_reg(REG_REPORT_LINES, 16'd1);
    write_reg(REG_DATA_BITS, 16'd1);
    send_sample(1'b0, 1'b1, 8'hFF);
    send_sample(1'b1, 1'b0, 8'h00);
    drain();
    write_reg(REG_REPORT_FRAMES, 16'd1);
    write_reg(REG_DATA_BITS, 16'd8);
    send_sample(1'b0, 1'b1, 8'h3C);
    drain();
    write_reg(REG_FRAMES_TO_DECODE, 16'd0);
    send_sample(1'b0, 1'b0, 8'h00);
    send_sample(1'b1, 1'b0, 8'h00);
    send_sample(1'b0, 1'b1, 8'h77);
    drain();
  endtask

  // One long line followed by many one-byte lines in the same frame
  task automatic test_long_line_many_lines();
    write_reg(REG_FRAMES_TO_DECODE, 16'd1);
    send_sample(1'b1, 1'b0, 8'h00);
    repeat (64) send_sample(1'b0, 1'b1, 8'($urandom_range(255)));
    send_sample(1'b0, 1'b0, 8'h00);
    repeat (24) begin
      send_sample(1'b0, 1'b1, 8'($urandom_range(255)));
      send_sample(1'b0, 1'b0, 8'h00);
    end
    send_sample(1'b1, 1'b0, 8'h00);
    drain();
  endtask

  task automatic send_random_frame();
    int unsigned nlines;
    int unsigned len;
    nlines = $urandom_range(0, 4);
    repeat ($urandom_range(1, 3)) send_sample(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
    if ($urandom_range(1)) send_sample(1'b0, 1'b0, 8'($urandom_range(255)));
    repeat (nlines) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      repeat (len) send_sample(($urandom_range(9) == 0), 1'b1, 8'($urandom_range(255)));
      repeat ($urandom_range(0, 3)) send_sample(1'b0, 1'b0, 8'($urandom_range(255)));
    end
    send_sample(1'b1, 1'b0, 8'($urandom_range(255)));
  endtask

  // Well-formed frames with random content, mixed with noise bursts
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned target;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      write_reg(REG_FRAMES_TO_DECODE, (phase == 0) ? 16'hFFFF : 16'($urandom_range(1000, 65535)));
      write_reg(REG_DATA_BITS, 16'($urandom_range(0, 15)));
      write_reg(REG_REPORT_LINES, 16'($urandom_range(3) != 0));
      write_reg(REG_REPORT_FRAMES, 16'($urandom_range(3) != 0));
      // hold the receiver off while samples keep coming
      if (phase == 0) hold_request = 1'b1;
      target = samples_used + 150;
      while (samples_used < target) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 6))
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
        end else begin
          send_random_frame();
        end
      end
      drain();
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_request && !hold_served) begin
      hold_served = 1'b1;
      stall_hold  = 300;
    end
    if (stall_hold > 0) begin
      out_stall_i <= 1'b1;
      stall_hold  = stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        $error("result with nothing expected: kind %0d", out_data_o.kind);
        mismatches++;
      end else begin
        want = pending.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data_o.kind));
        check_field("pixel_value", 32'(want.pixel_value), 32'(out_data_o.pixel_value));
        check_field("count_value", want.count_value, out_data_o.count_value);
        check_field("lines_in_frame", 32'(want.lines_in_frame),
                    32'(out_data_o.lines_in_frame));
        check_field("length_mismatch", 32'(want.length_mismatch),
                    32'(out_data_o.length_mismatch));
        check_field("last", 32'(want.last), 32'(out_data_o.last));
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_sync_cases();
    test_register_settings();
    test_long_line_many_lines();
    test_random_traffic();
    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
